[sv/timestamp_tick_accumulator_macros.svh]
// Assertion macros for the timestamp tick accumulator.
// Both macros sample on clk_i and are quiet while rst_ni is low.
`ifndef TIMESTAMP_TICK_ACCUMULATOR_MACROS_SVH
`define TIMESTAMP_TICK_ACCUMULATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge.
`define TTA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("timestamp_tick_accumulator: assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define TTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timestamp_tick_accumulator: sequence assertion failed");

`else

`define TTA_ASSERT(lbl, prop)
`define TTA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[sv/ttacc_pkg.sv]
package ttacc_pkg;

  // Field widths
  localparam int unsigned AmountW = 32;
  localparam int unsigned SecW    = 63;
  localparam int unsigned NsecW   = 30;
  localparam int unsigned ProdW   = 2 * AmountW;
  localparam int unsigned SumW    = AmountW + 1;
  localparam int unsigned OutW    = 96;

  // Iteration counts of the serial units
  localparam int unsigned MulSteps = AmountW;
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned MulCntW  = $clog2(MulSteps);
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [AmountW-1:0] NsPerSec       = 32'd1000000000;
  localparam logic [AmountW-1:0] SampleRateRst  = 32'd48000;

  // Input kinds carried in tuser
  localparam logic ModeNsec = 1'b0;
  localparam logic ModeTick = 1'b1;

  typedef struct packed {
    logic start;
  } step_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } step_stat_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StDiv  = 5'b00100,
    StNorm = 5'b01000,
    StEmit = 5'b10000
  } state_e;

endpackage

[sv/ttacc_mul.sv]
module ttacc_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttacc_pkg::step_ctrl_t         ctrl_i,
  input  logic [ttacc_pkg::AmountW-1:0] ticks_i,
  output ttacc_pkg::step_stat_t         stat_o,
  output logic [ttacc_pkg::ProdW-1:0]   product_o
);
  import ttacc_pkg::*;

  logic [ProdW-1:0]   acc_q, acc_d;
  logic [MulCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [AmountW:0]   hi_sum;

  // Add the constant into the high half when the low multiplier bit is set
  always_comb begin
    hi_sum = {1'b0, acc_q[ProdW-1:AmountW]} + (acc_q[0] ? {1'b0, NsPerSec} : '0);
  end

  // Shift one multiplier bit per cycle
  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      acc_d  = {{AmountW{1'b0}}, ticks_i};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {hi_sum, acc_q[AmountW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MulCntW'(MulSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign product_o   = acc_q;

endmodule

[sv/ttacc_div.sv]
module ttacc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttacc_pkg::step_ctrl_t         ctrl_i,
  input  logic [ttacc_pkg::ProdW-1:0]   dividend_i,
  input  logic [ttacc_pkg::AmountW-1:0] divisor_i,
  output ttacc_pkg::step_stat_t         stat_o,
  output logic [ttacc_pkg::AmountW-1:0] quotient_o
);
  import ttacc_pkg::*;

  logic [ProdW-1:0]   dq_q, dq_d;
  logic [AmountW-1:0] rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [AmountW:0]   trial;
  logic [AmountW:0]   diff;
  logic               fits;

  // Bring down the next dividend bit and try a subtract; a zero divisor
  // always fits, so the quotient comes out all ones
  always_comb begin
    trial = {rem_q, dq_q[ProdW-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = trial >= {1'b0, divisor_i};
  end

  // Retire one quotient bit per cycle
  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dq_d  = {dq_q[ProdW-2:0], fits};
      rem_d = fits ? diff[AmountW-1:0] : trial[AmountW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dq_q[AmountW-1:0];

endmodule

[sv/timestamp_tick_accumulator.sv]
// Channel  Dir  Beat contents (low bit first)              Handshake
// s_axis   in   tdata: amount[31:0]; tuser: mode          tvalid/tready
// m_axis   out  tdata: seconds[62:0], nanoseconds[92:63]  tvalid/tready
// cfg      in   cfg_wdata_i: tick_rate[31:0]              cfg_we_i
//
// A nanosecond beat goes to normalization, which folds out each carried second
// (at most 5), then to the emit step. A tick beat first runs the shift-add
// multiplier (32 steps) and the restoring divider (64 steps) before normalizing;
// one beat is in work at a time.
// Reset clears seconds and nanoseconds and loads the tick rate with 48000.
// A held result does not stop the next input beat; only the emit step waits for it.
`include "timestamp_tick_accumulator_macros.svh"

module timestamp_tick_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,   // tick_rate[31:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // amount[31:0]
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // seconds[62:0], nanoseconds[92:63], zero pad
);
  import ttacc_pkg::*;

  state_e             state_q, state_d;
  logic [AmountW-1:0] rate_q;
  logic [SecW-1:0]    sec_q, sec_d;
  logic [NsecW-1:0]   nsec_q, nsec_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic               out_valid_q, out_valid_d;
  logic [OutW-1:0]    out_data_q, out_data_d;
  logic               in_fire;
  logic               sum_carry;

  step_ctrl_t         mul_ctrl, div_ctrl;
  step_stat_t         mul_stat, div_stat;
  logic [ProdW-1:0]   product;
  logic [AmountW-1:0] quotient;

  ttacc_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mul_ctrl),
    .ticks_i   (s_axis_tdata),
    .stat_o    (mul_stat),
    .product_o (product)
  );

  ttacc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (product),
    .divisor_i  (rate_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign sum_carry     = sum_q >= {1'b0, NsPerSec};

  // Sequence the conversion, then fold whole seconds out one per cycle
  always_comb begin
    state_d        = state_q;
    sec_d          = sec_q;
    nsec_d         = nsec_q;
    sum_d          = sum_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    out_data_d     = out_data_q;
    mul_ctrl.start = 1'b0;
    div_ctrl.start = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (s_axis_tuser == ModeTick) begin
            mul_ctrl.start = 1'b1;
            state_d        = StMul;
          end else begin
            sum_d   = {{(SumW-NsecW){1'b0}}, nsec_q} + {1'b0, s_axis_tdata};
            state_d = StNorm;
          end
        end
      end
      StMul: begin
        if (mul_stat.done) begin
          div_ctrl.start = 1'b1;
          state_d        = StDiv;
        end
      end
      StDiv: begin
        if (div_stat.done) begin
          sum_d   = {{(SumW-NsecW){1'b0}}, nsec_q} + {1'b0, quotient};
          state_d = StNorm;
        end
      end
      StNorm: begin
        if (sum_carry) begin
          sum_d = sum_q - {1'b0, NsPerSec};
          sec_d = sec_q + 1'b1;
        end else begin
          nsec_d  = sum_q[NsecW-1:0];
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {{(OutW-SecW-NsecW){1'b0}}, nsec_q, sec_q};
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rate_q      <= SampleRateRst;
      sec_q       <= '0;
      nsec_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sec_q       <= sec_d;
      nsec_q      <= nsec_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `TTA_ASSERT(a_nsec_range, nsec_q < NsPerSec[NsecW-1:0])
  `TTA_ASSERT(a_idle_units_quiet, (state_q == StIdle) |-> (!mul_stat.busy && !div_stat.busy))
  `TTA_ASSERT_NEXT(a_mul_to_div, (state_q == StMul) && mul_stat.done, div_stat.busy)
  `TTA_ASSERT(a_valid_from_emit, $rose(out_valid_q) |-> $past(state_q == StEmit))

endmodule
